// File: design/gtlw_pkg.sv
// ----------------------------------------------------------------------------
// gtlw_pkg
// shared types and codes for the glyph text layout wrap block
// ----------------------------------------------------------------------------
package gtlw_pkg;

  // item commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_CODE  = 2'd0;
  localparam logic [1:0] CFG_END_CODE    = 2'd1;
  localparam logic [1:0] CFG_LINE_HEIGHT = 2'd2;

  localparam int CFG_DATA_W = 16;

  // character code that forces a line break
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // reset values of the configuration registers
  localparam logic [7:0]  FIRST_CODE_RST  = 8'd1;
  localparam logic [8:0]  END_CODE_RST    = 9'd128;
  localparam logic [15:0] LINE_HEIGHT_RST = 16'd0;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         code;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [22:0]        wrap_width;
    logic               wrap_on;
    logic [15:0]        atlas_x;
    logic [15:0]        atlas_y;
    logic [15:0]        glyph_w;
    logic [15:0]        glyph_h;
    logic               visible;
  } gtlw_in_t;

  typedef struct packed {
    logic signed [23:0] dest_x;
    logic signed [23:0] dest_y;
    logic [15:0]        src_x;
    logic [15:0]        src_y;
    logic [15:0]        src_w;
    logic [15:0]        src_h;
  } gtlw_out_t;

  // one glyph table entry
  typedef struct packed {
    logic        visible;
    logic [15:0] glyph_h;
    logic [15:0] glyph_w;
    logic [15:0] atlas_y;
    logic [15:0] atlas_x;
  } gtlw_glyph_t;

endpackage

// File: design/gtlw_glyph_ram.sv
// ----------------------------------------------------------------------------
// gtlw_glyph_ram
// glyph table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module gtlw_glyph_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  gtlw_pkg::gtlw_glyph_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output gtlw_pkg::gtlw_glyph_t rd_data
);
  import gtlw_pkg::*;

  gtlw_glyph_t mem [DEPTH];
  gtlw_glyph_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/glyph_text_layout_wrap_core.sv
// ----------------------------------------------------------------------------
// glyph_text_layout_wrap_core
// text layout for a character overlay: glyph table, cursor and line wrap
// ----------------------------------------------------------------------------
//
//  channel | ports                              | direction | beat
//  --------+------------------------------------+-----------+------------------
//  in      | in_valid, in_stall, in_data        | in        | one item
//  out     | out_valid, out_stall, out_data     | out       | one draw command
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | in        | one register write
//          | cfg_data                           |           |
//
//  one item is taken every cycle while in_stall is low; a draw command leaves
//  through the glyph table read, then the cursor stage into the out reg
//  the cursor add and wrap compare form the cursor stage, which carries cursor
//  state from item to item
//  reset (rst_n low, synchronous) clears control, cursor and config registers;
//  the glyph table is not cleared and holds garbage until written
//  in_stall rises only when the cursor stage holds a draw command and the
//  output register is full and stalled
//
module glyph_text_layout_wrap_core #(
  parameter int GLYPH_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gtlw_pkg::gtlw_in_t                   in_data,
  // draw command output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gtlw_pkg::gtlw_out_t                  out_data,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [gtlw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gtlw_pkg::*;

  localparam int IDX_W = $clog2(GLYPH_ENTRIES);
  localparam logic [8:0] ENTRIES_9 = 9'(GLYPH_ENTRIES);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  first_code_r;
  logic [8:0]  end_code_r;
  logic [15:0] line_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r  <= FIRST_CODE_RST;
      end_code_r    <= END_CODE_RST;
      line_height_r <= LINE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_CODE:  first_code_r  <= cfg_data[7:0];
        CFG_END_CODE:    end_code_r    <= cfg_data[8:0];
        CFG_LINE_HEIGHT: line_height_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: decode, glyph write, glyph read issue
  // --------------------------------------------------------------------------
  logic        in_accept;
  logic        is_write;
  logic        is_begin;
  logic        is_text;
  logic [7:0]  text_idx;
  logic        text_ok;
  logic        wr_ok;
  logic        s0_go;

  assign in_accept = in_valid && !in_stall;
  assign is_write  = (in_data.cmd == CMD_WRITE);
  assign is_begin  = (in_data.cmd == CMD_BEGIN);
  assign is_text   = (in_data.cmd == CMD_TEXT);
  assign text_idx  = in_data.code - first_code_r;

  // code in the configured range and its glyph inside the table
  assign text_ok = is_text
                && (in_data.code >= first_code_r)
                && ({1'b0, in_data.code} < end_code_r)
                && ({1'b0, text_idx} < ENTRIES_9);

  // writes beyond the table are dropped
  assign wr_ok = is_write && ({1'b0, in_data.code} < ENTRIES_9);

  // only begin and in-range text items move on to the cursor stage
  assign s0_go = in_accept && (is_begin || text_ok);

  gtlw_glyph_t wr_glyph;
  gtlw_glyph_t rd_glyph;

  always_comb begin
    wr_glyph.visible = in_data.visible;
    wr_glyph.glyph_h = in_data.glyph_h;
    wr_glyph.glyph_w = in_data.glyph_w;
    wr_glyph.atlas_y = in_data.atlas_y;
    wr_glyph.atlas_x = in_data.atlas_x;
  end

  // a write lands at its accept edge, so a text item right behind it reads
  // the new entry without any forwarding
  gtlw_glyph_ram #(
    .DEPTH (GLYPH_ENTRIES),
    .AW    (IDX_W)
  ) u_glyph_ram (
    .clk     (clk),
    .wr_en   (in_accept && wr_ok),
    .wr_addr (in_data.code[IDX_W-1:0]),
    .wr_data (wr_glyph),
    .rd_en   (in_accept && text_ok),
    .rd_addr (text_idx[IDX_W-1:0]),
    .rd_data (rd_glyph)
  );

  // --------------------------------------------------------------------------
  // stage 1: cursor update, wrap test, draw command build
  // --------------------------------------------------------------------------
  logic               s1_valid_r;
  logic               s1_begin_r;
  logic               s1_nl_r;
  logic signed [23:0] s1_origin_x_r;
  logic signed [23:0] s1_origin_y_r;
  logic [22:0]        s1_wrap_width_r;
  logic               s1_wrap_on_r;

  logic [23:0] cursor_x_r;
  logic [23:0] cursor_y_r;
  logic [23:0] line_start_x_r;
  logic [22:0] wrap_limit_r;
  logic        wrap_enabled_r;

  logic        out_valid_r;
  logic        s1_emit;
  logic        s1_adv;

  // a text item draws only when its glyph is visible
  assign s1_emit  = !s1_begin_r && rd_glyph.visible;
  // cursor stage is held only by a draw command facing a full stalled output
  assign s1_adv   = !(s1_valid_r && s1_emit && out_valid_r && out_stall);
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= s0_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s0_go) begin
      s1_begin_r      <= is_begin;
      s1_nl_r         <= (in_data.code == NEWLINE_CODE);
      s1_origin_x_r   <= in_data.origin_x;
      s1_origin_y_r   <= in_data.origin_y;
      s1_wrap_width_r <= in_data.wrap_width;
      s1_wrap_on_r    <= in_data.wrap_on;
    end
  end

  // span = glyph_w + cursor_x - line_start_x, exact in 27 signed bits
  logic signed [26:0] span;
  logic               brk;
  logic [23:0]        draw_x;
  logic [23:0]        draw_y;
  logic [23:0]        adv_from_cur;
  logic [23:0]        adv_from_start;
  logic [23:0]        cursor_x_nxt;

  assign span = $signed({11'd0, rd_glyph.glyph_w})
              + {{3{cursor_x_r[23]}}, cursor_x_r}
              - {{3{line_start_x_r[23]}}, line_start_x_r};

  assign brk = s1_nl_r || (wrap_enabled_r && (span > $signed({4'd0, wrap_limit_r})));

  assign draw_x = brk ? line_start_x_r : cursor_x_r;
  assign draw_y = brk ? (cursor_y_r + {8'd0, line_height_r}) : cursor_y_r;

  // both advance sums run beside the wrap compare
  assign adv_from_cur   = cursor_x_r     + {8'd0, rd_glyph.glyph_w};
  assign adv_from_start = line_start_x_r + {8'd0, rd_glyph.glyph_w};

  always_comb begin
    if (s1_nl_r) begin
      cursor_x_nxt = line_start_x_r;
    end else if (brk) begin
      cursor_x_nxt = adv_from_start;
    end else begin
      cursor_x_nxt = adv_from_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      line_start_x_r <= '0;
      wrap_limit_r   <= '0;
      wrap_enabled_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      if (s1_begin_r) begin
        cursor_x_r     <= s1_origin_x_r;
        cursor_y_r     <= s1_origin_y_r;
        line_start_x_r <= s1_origin_x_r;
        wrap_limit_r   <= s1_wrap_width_r;
        wrap_enabled_r <= s1_wrap_on_r;
      end else begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= draw_y;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  gtlw_out_t out_data_r;
  logic      s1_fire;

  assign s1_fire = s1_valid_r && s1_emit && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.dest_x <= draw_x;
      out_data_r.dest_y <= draw_y;
      out_data_r.src_x  <= rd_glyph.atlas_x;
      out_data_r.src_y  <= rd_glyph.atlas_y;
      out_data_r.src_w  <= rd_glyph.glyph_w;
      out_data_r.src_h  <= rd_glyph.glyph_h;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // input backs up only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a blocked draw command");

  // a retired visible glyph shows up at the output next cycle
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("draw command lost between cursor stage and output");

  // a begin item puts the cursor at the new line start
  a_begin_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_begin_r && s1_adv) |=> (cursor_x_r == line_start_x_r))
    else $error("cursor not at line start after begin");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
